// File: rtl/core/rnl_pkg.sv
`default_nettype none

package rnl_pkg;

  localparam int unsigned ROUTE_DEPTH_DEFAULT    = 128;
  localparam int unsigned NEIGHBOR_DEPTH_DEFAULT = 128;

  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned CFG_INDEX_W = 1;

  // command codes
  localparam logic [1:0] CMD_ROUTE_WR = 2'd0;
  localparam logic [1:0] CMD_NEIGH_WR = 2'd1;
  localparam logic [1:0] CMD_LOOKUP   = 2'd2;

  // status codes
  localparam logic [1:0] ST_FORWARD  = 2'd0;
  localparam logic [1:0] ST_EXPIRED  = 2'd1;
  localparam logic [1:0] ST_NO_ROUTE = 2'd2;
  localparam logic [1:0] ST_NO_NEIGH = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ROUTE_COUNT    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEIGHBOR_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  entry_index;
    logic [31:0] address;
    logic [31:0] prefix_mask;
    logic [31:0] hop_address;
    logic [7:0]  port_number;
    logic [47:0] mac_address;
    logic [7:0]  ttl_in;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_port;
    logic [31:0] next_hop_ip;
    logic [47:0] dest_mac;
    logic [7:0]  ttl_out;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/route_and_neighbor_lookup.sv
`default_nettype none

// Forwarding lookup engine with a linear route table and a linear neighbor
// table, both held in synchronous memories with one write and one read
// port each. A command is transferred when start is high and busy is low.
// Route and neighbor writes complete in the transfer cycle and leave busy
// low, so a command may follow in the very next cycle. A lookup whose TTL
// is 1 or less answers with the expired status in the cycle after its
// transfer, also without raising busy. Any other lookup raises busy and
// walks the route memory one entry per cycle (route_count entries,
// saturated to ROUTE_DEPTH); with no route match it answers no-route, else
// it walks the neighbor memory one entry per cycle until the first IP match
// or the end of neighbor_count entries, each walk paced by one read port.
// The result is shown for exactly one cycle with result_valid high; the
// receiver cannot stall it, and busy drops in the cycle the result appears.
// Configuration writes (cfg_ready is always high) must be made while idle.
module route_and_neighbor_lookup #(
  parameter int unsigned ROUTE_DEPTH    = rnl_pkg::ROUTE_DEPTH_DEFAULT,
  parameter int unsigned NEIGHBOR_DEPTH = rnl_pkg::NEIGHBOR_DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire rnl_pkg::item_t                   item,
  output logic                                  result_valid,
  output rnl_pkg::result_t                      result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rnl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [rnl_pkg::COUNT_W-1:0]      cfg_data
);
  import rnl_pkg::*;

  // memory address and scan counter widths
  localparam int unsigned RA_W = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
  localparam int unsigned NA_W = (NEIGHBOR_DEPTH > 1) ? $clog2(NEIGHBOR_DEPTH) : 1;
  localparam int unsigned RC_W = $clog2(ROUTE_DEPTH + 1);
  localparam int unsigned NC_W = $clog2(NEIGHBOR_DEPTH + 1);

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [7:0]  port;
  } route_entry_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } neigh_entry_t;

  typedef enum logic [1:0] {
    IDLE,
    ROUTE_SCAN,
    NEIGH_SCAN
  } state_t;

  state_t state;

  // configuration registers
  logic [COUNT_W-1:0] route_count;
  logic [COUNT_W-1:0] neighbor_count;

  // lookup context
  logic [31:0]     dst;
  logic [7:0]      ttl;
  logic            found;
  logic [31:0]     best_mask;
  logic [31:0]     best_hop;
  logic [7:0]      best_port;
  logic [RC_W-1:0] ridx;
  logic [NC_W-1:0] nidx;
  logic            rvalid;
  logic            nvalid;

  // memories
  route_entry_t route_mem [ROUTE_DEPTH];
  neigh_entry_t neigh_mem [NEIGHBOR_DEPTH];
  route_entry_t route_rdata;
  neigh_entry_t neigh_rdata;

  logic            accept;
  logic            route_we;
  logic            neigh_we;
  logic [RA_W-1:0] route_waddr;
  logic [NA_W-1:0] neigh_waddr;
  logic [RC_W-1:0] rcnt;
  logic [NC_W-1:0] ncnt;
  logic            route_more;
  logic            neigh_more;
  logic            route_hit;
  logic            route_better;
  logic            neigh_hit;

  assign cfg_ready = 1'b1;
  assign busy      = (state != IDLE);
  assign accept    = start && !busy;

  // table writes; a slot beyond the memory depth is dropped
  assign route_we = accept && (item.cmd == CMD_ROUTE_WR)
                    && (32'(item.entry_index) < 32'(ROUTE_DEPTH));
  assign neigh_we = accept && (item.cmd == CMD_NEIGH_WR)
                    && (32'(item.entry_index) < 32'(NEIGHBOR_DEPTH));
  assign route_waddr = RA_W'(item.entry_index);
  assign neigh_waddr = NA_W'(item.entry_index);

  // counts saturate at the table depth
  assign rcnt = (32'(route_count) > 32'(ROUTE_DEPTH)) ? RC_W'(ROUTE_DEPTH)
                                                      : RC_W'(route_count);
  assign ncnt = (32'(neighbor_count) > 32'(NEIGHBOR_DEPTH)) ? NC_W'(NEIGHBOR_DEPTH)
                                                            : NC_W'(neighbor_count);

  // another entry still to be read
  assign route_more = (ridx < rcnt);
  assign neigh_more = (nidx < ncnt);

  // compare on the entry read out in the previous cycle
  assign route_hit    = rvalid && ((dst & route_rdata.mask)
                                   == (route_rdata.prefix & route_rdata.mask));
  assign route_better = route_hit && (!found || (route_rdata.mask > best_mask));
  assign neigh_hit    = nvalid && (neigh_rdata.ip == best_hop);

  // route memory: one write and one read per cycle, read data registered
  always_ff @(posedge clk) begin
    if (route_we) begin
      route_mem[route_waddr] <= '{prefix: item.address, mask: item.prefix_mask,
                                  hop: item.hop_address, port: item.port_number};
    end
    route_rdata <= route_mem[ridx[RA_W-1:0]];
  end

  // neighbor memory
  always_ff @(posedge clk) begin
    if (neigh_we) begin
      neigh_mem[neigh_waddr] <= '{ip: item.address, mac: item.mac_address};
    end
    neigh_rdata <= neigh_mem[nidx[NA_W-1:0]];
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      route_count    <= '0;
      neighbor_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROUTE_COUNT:    route_count    <= cfg_data;
        CFG_NEIGHBOR_COUNT: neighbor_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // lookup sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
      rvalid       <= 1'b0;
      nvalid       <= 1'b0;
    end else begin
      // strobes last one cycle unless set below
      result_valid <= 1'b0;
      rvalid       <= 1'b0;
      nvalid       <= 1'b0;

      case (state)
        IDLE: begin
          if (accept && (item.cmd == CMD_LOOKUP)) begin
            if (item.ttl_in <= 8'd1) begin
              // expired: answer at once, table untouched
              result_valid <= 1'b1;
              result       <= '{status: ST_EXPIRED, out_port: '0, next_hop_ip: '0,
                                dest_mac: '0, ttl_out: item.ttl_in};
            end else begin
              dst   <= item.address;
              ttl   <= item.ttl_in;
              found <= 1'b0;
              ridx  <= '0;
              state <= ROUTE_SCAN;
            end
          end
        end

        ROUTE_SCAN: begin
          // longest mask wins, first entry kept on a tie
          if (route_better) begin
            found     <= 1'b1;
            best_mask <= route_rdata.mask;
            best_hop  <= route_rdata.hop;
            best_port <= route_rdata.port;
          end
          if (route_more) begin
            ridx   <= ridx + RC_W'(1);
            rvalid <= 1'b1;
          end else if (!rvalid) begin
            // every entry compared
            if (!found) begin
              result_valid <= 1'b1;
              result       <= '{status: ST_NO_ROUTE, out_port: '0, next_hop_ip: '0,
                                dest_mac: '0, ttl_out: ttl};
              state        <= IDLE;
            end else begin
              nidx  <= '0;
              state <= NEIGH_SCAN;
            end
          end
        end

        NEIGH_SCAN: begin
          if (neigh_hit) begin
            // first matching neighbor, reads still in flight are dropped
            result_valid <= 1'b1;
            result       <= '{status: ST_FORWARD, out_port: best_port,
                              next_hop_ip: best_hop, dest_mac: neigh_rdata.mac,
                              ttl_out: ttl - 8'd1};
            state        <= IDLE;
          end else if (neigh_more) begin
            nidx   <= nidx + NC_W'(1);
            nvalid <= 1'b1;
          end else if (!nvalid) begin
            result_valid <= 1'b1;
            result       <= '{status: ST_NO_NEIGH, out_port: '0, next_hop_ip: best_hop,
                              dest_mac: '0, ttl_out: ttl};
            state        <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
